// ===== hw/rtl/dfsw_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the depth-first search walk unit
// no dependencies

package dfsw_pkg;

  localparam int MaxVertices = 16;
  localparam int MaxDegree   = 16;

  localparam int VtxW  = $clog2(MaxVertices);         // vertex index
  localparam int CntW  = 5;                           // vertex_count register
  localparam int PosW  = $clog2(MaxDegree);           // list position index
  localparam int DegW  = $clog2(MaxDegree + 1);       // degree count
  localparam int SpW   = $clog2(MaxVertices + 1);     // stack depth
  localparam int TimeW = 6;                           // time stamps
  localparam int ParW  = 5;                           // parent, root code included
  localparam int AdjAw = VtxW + PosW;
  localparam int AdjDepth = MaxVertices * MaxDegree;

  localparam logic [CntW-1:0] CountReset = CntW'(MaxVertices);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_DROPPED  = 2'd1,
    KIND_FINISHED = 2'd2,
    KIND_CLEARED  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_TOP,
    ST_EDGE
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] from_vertex;
    logic [3:0] to_vertex;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] vertex;
    logic [5:0] discovery_time;
    logic [5:0] finish_time;
    logic [4:0] parent_vertex;
    logic       tree_end;
    logic       last;
  } out_item_t;

endpackage

// ===== hw/rtl/dfsw_ram.sv =====
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module dfsw_ram #(
  parameter int Width = 4,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/depth_first_search_walk_unit.sv =====
`timescale 1ns / 1ps
// depth-first search walk over adjacency lists, top level
// depends on dfsw_pkg and dfsw_ram
//
// add edge and clear: result beat registered in the cycle after the input beat, one
// item per cycle while the output is not stalled; run: after the accepting step, each
// tree root started or visited root skipped takes a root step, each stored edge looked
// at a top step fetching from the single adjacency ram read port and then an edge step,
// each vertex finish a top step that waits on result stalls; no new item during a run
// reset: degree counts, visit marks, stack depth, time and vertex_count (16) restored
// at once; the adjacency store keeps no reset and needs no clearing pass

module depth_first_search_walk_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dfsw_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dfsw_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [4:0]          cfg_data_i
);

  localparam int NV   = dfsw_pkg::MaxVertices;
  localparam int VtxW = dfsw_pkg::VtxW;
  localparam int CntW = dfsw_pkg::CntW;
  localparam int PosW = dfsw_pkg::PosW;
  localparam int DegW = dfsw_pkg::DegW;
  localparam int SpW  = dfsw_pkg::SpW;
  localparam int TimeW = dfsw_pkg::TimeW;
  localparam int ParW = dfsw_pkg::ParW;
  localparam int AdjAw = dfsw_pkg::AdjAw;

  dfsw_pkg::state_e state_q, state_d;

  logic [CntW-1:0]  count_q;
  logic [DegW-1:0]  deg_q [NV];
  logic [NV-1:0]    vis_q;
  logic [SpW-1:0]   sp_q;
  logic [TimeW-1:0] time_q;
  logic [VtxW-1:0]  root_q;
  logic [CntW-1:0]  fin_q;
  logic             out_valid_q;
  dfsw_pkg::out_item_t out_data_q;
  dfsw_pkg::out_item_t out_data_d;

  logic [VtxW-1:0]  stk_v_q [NV];
  logic [DegW-1:0]  stk_p_q [NV];
  logic [TimeW-1:0] disc_q [NV];
  logic [ParW-1:0]  par_q [NV];

  logic [CntW-1:0]  n_eff;
  logic             out_free;
  logic             in_acc;
  logic             edge_ok;
  logic [VtxW-1:0]  top_idx;
  logic [VtxW-1:0]  top_v;
  logic [DegW-1:0]  top_p;
  logic             has_edge;
  logic [VtxW-1:0]  edge_w;
  logic             can_push;
  logic             is_last;
  logic [TimeW-1:0] time_inc;

  // sequencer strobes
  logic add_go, clr_go, run_go, root_go, root_skip, fetch, pop, push;

  // vertex_count of 0 acts as 1, above the maximum acts as the maximum
  always_comb begin
    if (count_q == '0) begin
      n_eff = CntW'(1);
    end else if (count_q > CntW'(NV)) begin
      n_eff = CntW'(NV);
    end else begin
      n_eff = count_q;
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == dfsw_pkg::ST_IDLE) && out_free);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign edge_ok = ({1'b0, in_data_i.from_vertex} < n_eff)
                && ({1'b0, in_data_i.to_vertex} < n_eff)
                && (deg_q[in_data_i.from_vertex] < DegW'(dfsw_pkg::MaxDegree));

  assign top_idx  = sp_q[VtxW-1:0] - 1'b1;
  assign top_v    = stk_v_q[top_idx];
  assign top_p    = stk_p_q[top_idx];
  assign has_edge = top_p < deg_q[top_v];
  assign can_push = ({1'b0, edge_w} < n_eff) && !vis_q[edge_w] && (sp_q < SpW'(NV));
  assign is_last  = fin_q == (n_eff - 1'b1);
  assign time_inc = time_q + 1'b1;

  dfsw_ram #(
    .Width (VtxW),
    .Depth (dfsw_pkg::AdjDepth)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (add_go && edge_ok),
    .waddr_i ({in_data_i.from_vertex, deg_q[in_data_i.from_vertex][PosW-1:0]}),
    .wdata_i (in_data_i.to_vertex),
    .re_i    (fetch),
    .raddr_i (AdjAw'({top_v, top_p[PosW-1:0]})),
    .rdata_o (edge_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfsw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    add_go    = 1'b0;
    clr_go    = 1'b0;
    run_go    = 1'b0;
    root_go   = 1'b0;
    root_skip = 1'b0;
    fetch     = 1'b0;
    pop       = 1'b0;
    push      = 1'b0;
    case (state_q)
      dfsw_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.operation)
            dfsw_pkg::OP_ADD:   add_go = 1'b1;
            dfsw_pkg::OP_CLEAR: clr_go = 1'b1;
            dfsw_pkg::OP_RUN: begin
              run_go  = 1'b1;
              state_d = dfsw_pkg::ST_ROOT;
            end
            default: ;
          endcase
        end
      end
      dfsw_pkg::ST_ROOT: begin
        if (!vis_q[root_q]) begin
          root_go = 1'b1;
          state_d = dfsw_pkg::ST_TOP;
        end else begin
          root_skip = 1'b1;
        end
      end
      dfsw_pkg::ST_TOP: begin
        if (has_edge) begin
          fetch   = 1'b1;
          state_d = dfsw_pkg::ST_EDGE;
        end else if (out_free) begin
          pop = 1'b1;
          if (is_last) begin
            state_d = dfsw_pkg::ST_IDLE;
          end else if (sp_q == SpW'(1)) begin
            state_d = dfsw_pkg::ST_ROOT;
          end
        end
      end
      dfsw_pkg::ST_EDGE: begin
        push    = can_push;
        state_d = dfsw_pkg::ST_TOP;
      end
      default: state_d = dfsw_pkg::ST_IDLE;
    endcase
  end

  // next result beat: a finished vertex, or the single beat of an add or clear
  always_comb begin
    out_data_d      = '0;
    out_data_d.last = 1'b1;
    if (pop) begin
      out_data_d.kind           = dfsw_pkg::KIND_FINISHED;
      out_data_d.vertex         = top_v;
      out_data_d.discovery_time = disc_q[top_v];
      out_data_d.finish_time    = time_inc;
      out_data_d.parent_vertex  = par_q[top_v];
      out_data_d.tree_end       = sp_q == SpW'(1);
      out_data_d.last           = is_last;
    end else if (clr_go) begin
      out_data_d.kind = dfsw_pkg::KIND_CLEARED;
    end else if (edge_ok) begin
      out_data_d.kind = dfsw_pkg::KIND_ACCEPTED;
    end else begin
      out_data_d.kind = dfsw_pkg::KIND_DROPPED;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= dfsw_pkg::CountReset;
      vis_q       <= '0;
      sp_q        <= '0;
      time_q      <= '0;
      root_q      <= '0;
      fin_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NV; i++) begin
        deg_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
      if (add_go || clr_go || pop) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (add_go && edge_ok) begin
        deg_q[in_data_i.from_vertex] <= deg_q[in_data_i.from_vertex] + 1'b1;
      end
      if (clr_go) begin
        for (int i = 0; i < NV; i++) begin
          deg_q[i] <= '0;
        end
      end
      if (run_go) begin
        vis_q  <= '0;
        sp_q   <= '0;
        time_q <= '0;
        root_q <= '0;
        fin_q  <= '0;
      end
      if (root_skip) begin
        root_q <= root_q + 1'b1;
      end
      if (root_go) begin
        vis_q[root_q] <= 1'b1;
        time_q        <= time_inc;
        sp_q          <= SpW'(1);
      end
      if (push) begin
        vis_q[edge_w] <= 1'b1;
        time_q        <= time_inc;
        sp_q          <= sp_q + 1'b1;
      end
      if (pop) begin
        sp_q   <= sp_q - 1'b1;
        time_q <= time_inc;
        fin_q  <= fin_q + 1'b1;
        // tree closed, next root scan resumes after this one
        if (sp_q == SpW'(1)) begin
          root_q <= root_q + 1'b1;
        end
      end
    end
  end

  // stack, stores and result payload
  always_ff @(posedge clk_i) begin
    if (root_go) begin
      disc_q[root_q]  <= time_inc;
      par_q[root_q]   <= ParW'(NV);
      stk_v_q[0]      <= root_q;
      stk_p_q[0]      <= '0;
    end
    if (fetch) begin
      stk_p_q[top_idx] <= top_p + 1'b1;
    end
    if (push) begin
      disc_q[edge_w]           <= time_inc;
      par_q[edge_w]            <= ParW'(top_v);
      stk_v_q[sp_q[VtxW-1:0]]  <= edge_w;
      stk_p_q[sp_q[VtxW-1:0]]  <= '0;
    end
    if (add_go || clr_go || pop) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_top_has_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dfsw_pkg::ST_TOP |-> sp_q != '0)
    else $error("stack empty while walking");

  a_stack_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(NV))
    else $error("stack depth beyond vertex count");

  a_time_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_q <= TimeW'(2 * NV))
    else $error("time counter beyond two stamps per vertex");

  a_edge_then_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dfsw_pkg::ST_EDGE |=> state_q == dfsw_pkg::ST_TOP)
    else $error("edge step not followed by stack top step");

  a_root_parent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == dfsw_pkg::KIND_FINISHED && out_data_o.tree_end
    |-> out_data_o.parent_vertex == ParW'(NV))
    else $error("tree end beat without root parent code");
`endif

endmodule
